// ----- rtl/sjfh_pkg.sv -----
// shared types, codes and helpers for the shortest-job-first heap scheduler
// used by sjfh_cell and shortest_job_first_heap_scheduler_top
package sjfh_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int POS_MAX_W      = 17;
  localparam int LVL_W          = 5;
  localparam int ADDR_W         = 16;
  localparam int ENTRY_W        = 64;
  localparam int TIME_W         = 48;
  localparam int WAIT_W         = 63;
  localparam int QSIZE_W        = 11;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_SERVE    = 2'd1;
  localparam logic [1:0] CMD_SET_TIME = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] arr;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    entry_t odd;
    entry_t even;
  } pair_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  level;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  level;
    logic              lane;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_SRV_RD,
    S_SRV_LAST,
    S_DN_CMP,
    S_WR_END,
    S_DONE
  } state_t;

  // sibling pairs kept at one heap level, trimmed at the last level
  function automatic int level_pairs(input int level, input int depth);
    int first;
    int last;
    first = 1 << level;
    last  = (depth < ((2 << level) - 1)) ? depth : ((2 << level) - 1);
    return (last - first + 2) >> 1;
  endfunction

  function automatic logic [LVL_W-1:0] msb_index(input logic [POS_MAX_W-1:0] p);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < POS_MAX_W; i++) begin
      if (p[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/sjfh_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module sjfh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sjfh_cell.sv -----
// one heap level: even and odd sibling rams, read data joined onto the chain
// depends on sjfh_pkg and sjfh_ram
module sjfh_cell
  import sjfh_pkg::*;
#(
  parameter int LEVEL = 1,
  parameter int PAIRS = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  rd_req_t rd_req,
  input  wr_req_t wr_req,
  input  pair_t   chain_in,
  output pair_t   chain_out
);

  localparam int AW = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic   rd_hit;
  logic   wr_hit;
  logic   sel;
  entry_t even_q;
  entry_t odd_q;

  assign rd_hit = rd_req.en && (rd_req.level == LVL_W'(LEVEL));
  assign wr_hit = wr_req.en && (wr_req.level == LVL_W'(LEVEL));

  sjfh_ram #(.WIDTH(ENTRY_W), .DEPTH(PAIRS)) u_even (
    .clk   (clk),
    .we    (wr_hit && !wr_req.lane),
    .waddr (wr_req.addr[AW-1:0]),
    .wdata (wr_req.data),
    .re    (rd_hit),
    .raddr (rd_req.addr[AW-1:0]),
    .rdata (even_q)
  );

  sjfh_ram #(.WIDTH(ENTRY_W), .DEPTH(PAIRS)) u_odd (
    .clk   (clk),
    .we    (wr_hit && wr_req.lane),
    .waddr (wr_req.addr[AW-1:0]),
    .wdata (wr_req.data),
    .re    (rd_hit),
    .raddr (rd_req.addr[AW-1:0]),
    .rdata (odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      sel <= rd_hit;
    end
  end

  assign chain_out = sel ? (chain_in | {odd_q, even_q}) : chain_in;

endmodule

// ----- rtl/shortest_job_first_heap_scheduler_top.sv -----
// Shortest-job-first scheduler on a binary min-heap of jobs keyed by length. Each input word
// carries a command: insert a job, serve the shortest job, or set the current time. Every word
// gives one result word with status, the served job, the time, the saturating total wait, the
// served count and the queue size. The root sits in a register and every deeper level of the
// heap is one cell holding that level's sibling pairs in two rams, so a sift walks the row of
// cells one level at a time. An insert reads each parent in S_UP_RD, compares and moves it
// in S_UP_CMP and writes the job in S_WR_END; a serve passes S_SRV_RD and S_SRV_LAST, does
// one child compare per level in S_DN_CMP and writes in S_WR_END, or skips the compare when
// at most one job is left. A refused word, a set-time, an unused command or the first insert
// into an empty heap goes straight to S_DONE. Each level's ram has a registered read ahead of
// the compare and move. One word is worked on at a time; a new one is taken while the previous
// result still waits at the output. The heap rams need no clearing after reset.
// depends on sjfh_pkg, sjfh_cell and sjfh_ram
module shortest_job_first_heap_scheduler_top
  import sjfh_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,  // arrival_time, job_length
  input  logic [1:0]   s_tuser,  // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [223:0] m_tdata,  // served_arrival, served_length, now_time, wait_total,
                                 // jobs_served, queue_size, zero fill
  output logic [1:0]   m_tuser   // status
);

  localparam int PW   = $clog2(HEAP_DEPTH + 1);
  localparam int NLVL = PW;

  state_t state;
  state_t state_next;

  logic [PW-1:0]     cnt;
  entry_t            root;
  logic [TIME_W-1:0] now;
  logic [WAIT_W-1:0] wsum;
  logic [31:0]       served;
  entry_t            x;
  logic [LVL_W-1:0]  lvl;
  logic [PW-1:0]     off;
  logic [PW-1:0]     pos;
  logic [1:0]        status;
  logic [31:0]       s_arr;
  logic [31:0]       s_len;
  logic [TIME_W-1:0] diff;

  rd_req_t rd_req;
  wr_req_t wr_req;
  pair_t   chain [NLVL];
  pair_t   rp;

  logic              accept;
  logic [1:0]        in_cmd;
  entry_t            in_entry;
  logic              full;
  logic              empty;
  logic [PW-1:0]     n_ins;
  logic [LVL_W-1:0]  ins_lvl;
  logic [PW-1:0]     ins_off;
  logic [LVL_W-1:0]  last_lvl;
  logic [PW-1:0]     last_off;
  logic [TIME_W:0]   tsum;
  logic [TIME_W-1:0] now_sat;
  logic [WAIT_W:0]   wadd;
  entry_t            pv_up;
  logic              up_swap;
  entry_t            xv;
  logic              has_kids;
  logic              r_ok;
  logic              pick_r;
  entry_t            pv_dn;
  logic              dn_stop;
  logic [PW-1:0]     child_pos;
  logic [PW-1:0]     child_off;
  logic              grand;
  logic              out_free;

  assign in_cmd   = s_tuser;
  assign in_entry = '{arr: s_tdata[31:0], len: s_tdata[63:32]};
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign full     = (cnt == PW'(HEAP_DEPTH));
  assign empty    = (cnt == '0);
  assign n_ins    = cnt + PW'(1);
  assign ins_lvl  = msb_index(POS_MAX_W'(n_ins));
  assign ins_off  = n_ins ^ (PW'(1) << ins_lvl);
  assign last_lvl = msb_index(POS_MAX_W'(cnt));
  assign last_off = cnt ^ (PW'(1) << last_lvl);

  assign tsum    = {1'b0, now} + (TIME_W + 1)'(root.len);
  assign now_sat = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
  assign wadd    = {1'b0, wsum} + (WAIT_W + 1)'(diff);

  // level cells, read data handed along the row
  assign chain[0] = '0;
  for (genvar g = 1; g < NLVL; g++) begin : g_cell
    sjfh_cell #(.LEVEL(g), .PAIRS(level_pairs(g, HEAP_DEPTH))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .rd_req    (rd_req),
      .wr_req    (wr_req),
      .chain_in  (chain[g-1]),
      .chain_out (chain[g])
    );
  end
  assign rp = chain[NLVL-1];

  // sift up
  assign pv_up   = (lvl == LVL_W'(1)) ? root : (off[1] ? rp.odd : rp.even);
  assign up_swap = (pv_up.len >= x.len);

  // sift down
  assign xv        = (lvl == '0) ? root : (off[0] ? rp.odd : rp.even);
  assign has_kids  = (cnt >= PW'(2));
  assign r_ok      = ({pos, 1'b1} <= {1'b0, cnt});
  assign pick_r    = r_ok && (rp.odd.len < rp.even.len);
  assign pv_dn     = pick_r ? rp.odd : rp.even;
  assign dn_stop   = (pv_dn.len > x.len);
  assign child_pos = {pos[PW-2:0], pick_r};
  assign child_off = {off[PW-2:0], pick_r};
  assign grand     = ({child_pos, 1'b0} <= {1'b0, cnt});

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INSERT: state_next = (full || ins_lvl == '0) ? S_DONE : S_UP_RD;
            CMD_SERVE:  state_next = empty ? S_DONE : S_SRV_RD;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_UP_RD:    state_next = S_UP_CMP;
      S_UP_CMP: begin
        if (up_swap && lvl != LVL_W'(1)) state_next = S_UP_RD;
        else state_next = S_WR_END;
      end
      S_SRV_RD:   state_next = S_SRV_LAST;
      S_SRV_LAST: state_next = has_kids ? S_DN_CMP : S_DONE;
      S_DN_CMP: begin
        if (dn_stop || !grand) state_next = S_WR_END;
        else state_next = S_DN_CMP;
      end
      S_WR_END:   state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_req       = '0;
    wr_req       = '0;
    wr_req.level = lvl;
    wr_req.lane  = off[0];
    wr_req.addr  = ADDR_W'(off >> 1);
    wr_req.data  = x;
    unique case (state)
      S_UP_RD: begin
        rd_req.en    = (lvl > LVL_W'(1));
        rd_req.level = lvl - LVL_W'(1);
        rd_req.addr  = ADDR_W'(off >> 2);
      end
      S_UP_CMP: begin
        wr_req.en   = up_swap;
        wr_req.data = pv_up;
      end
      S_SRV_RD: begin
        rd_req.en    = (lvl != '0);
        rd_req.level = lvl;
        rd_req.addr  = ADDR_W'(off >> 1);
      end
      S_SRV_LAST: begin
        rd_req.en    = has_kids;
        rd_req.level = LVL_W'(1);
        rd_req.addr  = '0;
      end
      S_DN_CMP: begin
        rd_req.en    = !dn_stop && grand;
        rd_req.level = lvl + LVL_W'(2);
        rd_req.addr  = ADDR_W'(child_off);
        wr_req.en    = !dn_stop && (lvl != '0);
        wr_req.data  = pv_dn;
      end
      S_WR_END: begin
        wr_req.en = (lvl != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      now      <= '0;
      wsum     <= '0;
      served   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_INSERT: begin
                s_arr <= '0;
                s_len <= '0;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  cnt    <= n_ins;
                  x      <= in_entry;
                  lvl    <= ins_lvl;
                  off    <= ins_off;
                  if (ins_lvl == '0) root <= in_entry;
                end
              end
              CMD_SERVE: begin
                if (empty) begin
                  status <= ST_EMPTY;
                  s_arr  <= '0;
                  s_len  <= '0;
                end else begin
                  status <= ST_OK;
                  s_arr  <= root.arr;
                  s_len  <= root.len;
                  now    <= now_sat;
                  served <= served + 32'd1;
                  cnt    <= cnt - PW'(1);
                  lvl    <= last_lvl;
                  off    <= last_off;
                end
              end
              CMD_SET_TIME: begin
                status <= ST_OK;
                s_arr  <= '0;
                s_len  <= '0;
                now    <= TIME_W'(in_entry.arr);
              end
              default: begin
                status <= ST_OK;
                s_arr  <= '0;
                s_len  <= '0;
              end
            endcase
          end
        end
        S_UP_CMP: begin
          if (up_swap) begin
            lvl <= lvl - LVL_W'(1);
            off <= off >> 1;
          end
        end
        S_SRV_RD: begin
          diff <= (now > TIME_W'(s_arr)) ? (now - TIME_W'(s_arr)) : '0;
        end
        S_SRV_LAST: begin
          x    <= xv;
          wsum <= wadd[WAIT_W] ? '1 : wadd[WAIT_W-1:0];
          lvl  <= '0;
          off  <= '0;
          pos  <= PW'(1);
          if (!has_kids) root <= xv;
        end
        S_DN_CMP: begin
          if (!dn_stop) begin
            if (lvl == '0) root <= pv_dn;
            lvl <= lvl + LVL_W'(1);
            off <= child_off;
            pos <= child_pos;
          end
        end
        S_WR_END: begin
          if (lvl == '0) root <= x;
        end
        S_DONE: begin
          if (out_free) begin
            m_tuser <= status;
            m_tdata <= {6'b0, QSIZE_W'(cnt), served, wsum, now, s_len, s_arr};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // checks

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= PW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_req.en && wr_req.en) |-> (rd_req.level != wr_req.level))
    else $error("read and write on the same level cell");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> ($past(state) == S_DONE))
    else $error("result word raised outside completion");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second word taken while one is in work");

endmodule
